// ----- rtl/tui_pkg.sv -----
// Package for the tensor unfold index block: status codes, register indexes,
// shared types. Used by tensor_unfold_index.
package tui_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_INDEX_OVER = 2'd1,
        ST_MODE_OVER  = 2'd2
    } t_status;

    localparam logic [CFG_IDX_W-1:0] REG_ORDER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIM0  = 3'd2;

    localparam int DIM_REGS = 6;

endpackage

// ----- rtl/tui_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// Standalone; the user must hold the divisor steady while items are in flight; the block does not enforce it.
module tui_div_pipe #(
    parameter int N  = 20,
    parameter int M  = 21,
    parameter int PW = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [N-1:0]  i_dividend,
    input  logic [M-1:0]  i_divisor,
    input  logic [PW-1:0] i_side,
    output logic          o_valid,
    output logic [N-1:0]  o_quot,
    output logic [M-1:0]  o_rem,
    output logic [PW-1:0] o_side
);

    logic [N-1:0]  r_vld;
    logic [M-1:0]  r_rem  [N];
    logic [N-1:0]  r_qd   [N];
    logic [PW-1:0] r_side [N];

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic [M-1:0]  p_rem;
        logic [N-1:0]  p_qd;
        logic [PW-1:0] p_side;
        logic          p_vld;
        logic [M:0]    shifted;
        logic [M:0]    diff;
        logic          ge;
        logic [M-1:0]  n_rem;
        logic [N-1:0]  n_qd;

        if (i == 0) begin : g_first
            assign p_rem  = '0;
            assign p_qd   = i_dividend;
            assign p_side = i_side;
            assign p_vld  = i_valid;
        end else begin : g_next
            assign p_rem  = r_rem[i-1];
            assign p_qd   = r_qd[i-1];
            assign p_side = r_side[i-1];
            assign p_vld  = r_vld[i-1];
        end

        always_comb begin
            shifted = {p_rem, p_qd[N-1]};
            diff    = shifted - {1'b0, i_divisor};
            ge      = shifted >= {1'b0, i_divisor};
            n_rem   = ge ? diff[M-1:0] : shifted[M-1:0];
            n_qd    = {p_qd[N-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[i]  <= n_rem;
                r_qd[i]   <= n_qd;
                r_side[i] <= p_side;
            end
        end
    end

    assign o_valid = r_vld[N-1];
    assign o_quot  = r_qd[N-1];
    assign o_rem   = r_rem[N-1];
    assign o_side  = r_side[N-1];

endmodule

// ----- rtl/tensor_unfold_index.sv -----
// Top level of the mode-k unfolding address generator.
// Depends on tui_pkg and tui_div_pipe.
//
//   channel  valid     ready     payload
//   in       i_valid   o_ready   i_linear_index
//   out      o_valid   i_ready   o_unfold_row, o_unfold_column, o_status
//   cfg      i_cfg_we  -         i_cfg_idx, i_cfg_data
//
// One item per cycle while the output is not stalled and the stride sequencer is idle; path: input register,
// two bit-per-stage dividers (index by stride, then by the size along mode k), multiply register, output register.
// After reset and after each register write a stride sequencer runs, one multiply per
// dimension slot; o_ready is low meanwhile.
// A stall on the output freezes the whole pipeline; nothing is lost.
module tensor_unfold_index #(
    parameter int MAX_ORDER  = 6,
    parameter int INDEX_BITS = 20,
    parameter int DIM_BITS   = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [INDEX_BITS-1:0]         i_linear_index,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [DIM_BITS-1:0]           o_unfold_row,
    output logic [INDEX_BITS-1:0]         o_unfold_column,
    output logic [1:0]                    o_status,
    input  logic                          i_cfg_we,
    input  logic [tui_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [((DIM_BITS > 3) ? DIM_BITS : 3)-1:0] i_cfg_data
);

    localparam int W      = INDEX_BITS + 1;
    localparam int ORD_W  = $clog2(MAX_ORDER + 1) + 1;
    localparam int STEP_W = $clog2(MAX_ORDER);
    localparam int PW     = W + DIM_BITS;
    localparam logic [W-1:0] LIM = {1'b1, {INDEX_BITS{1'b0}}};

    logic [2:0]          r_order;
    logic [2:0]          r_mode;
    logic [DIM_BITS-1:0] r_dim [tui_pkg::DIM_REGS];

    logic                r_busy;
    logic [STEP_W-1:0]   r_step;
    logic [W-1:0]        r_acc;
    logic [W-1:0]        r_stride;
    logic [W-1:0]        r_total;
    logic [DIM_BITS-1:0] r_size_k;

    logic [ORD_W-1:0]    ord_eff;
    logic                mode_bad;
    logic [DIM_BITS-1:0] slot_size [MAX_ORDER];
    logic [DIM_BITS-1:0] step_size;
    logic [PW-1:0]       prod;
    logic [W-1:0]        sat;
    logic                step_hit;

    logic                en;

    always_comb begin
        if (r_order == 3'd0) begin
            ord_eff = ORD_W'(1);
        end else if (ORD_W'(r_order) > ORD_W'(MAX_ORDER)) begin
            ord_eff = ORD_W'(MAX_ORDER);
        end else begin
            ord_eff = ORD_W'(r_order);
        end
        mode_bad = (r_mode == 3'd0) || (ORD_W'(r_mode) > ord_eff);
    end

    for (genvar j = 0; j < MAX_ORDER; j++) begin : g_slot
        if (j < tui_pkg::DIM_REGS) begin : g_reg
            assign slot_size[j] = ((ORD_W'(j) >= ord_eff) || (r_dim[j] == '0))
                                  ? DIM_BITS'(1) : r_dim[j];
        end else begin : g_one
            assign slot_size[j] = DIM_BITS'(1);
        end
    end

    always_comb begin
        step_size = slot_size[r_step];
        prod      = PW'(r_acc) * PW'(step_size);
        sat       = (prod > PW'(LIM)) ? LIM : prod[W-1:0];
        step_hit  = (ORD_W'(r_step) + ORD_W'(1)) == ORD_W'(r_mode);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= 3'd2;
            r_mode  <= 3'd1;
            for (int t = 0; t < tui_pkg::DIM_REGS; t++) begin
                r_dim[t] <= DIM_BITS'(1);
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tui_pkg::REG_ORDER: r_order <= i_cfg_data[2:0];
                tui_pkg::REG_MODE:  r_mode  <= i_cfg_data[2:0];
                default: r_dim[i_cfg_idx - tui_pkg::REG_DIM0] <= i_cfg_data[DIM_BITS-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_step <= STEP_W'(MAX_ORDER - 1);
            r_acc  <= W'(1);
        end else if (i_cfg_we) begin
            r_busy <= 1'b1;
            r_step <= STEP_W'(MAX_ORDER - 1);
            r_acc  <= W'(1);
        end else if (r_busy) begin
            r_acc <= sat;
            if (r_step == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && !i_cfg_we) begin
            if (step_hit) begin
                r_stride <= r_acc;
                r_size_k <= step_size;
            end
            if (r_step == '0) begin
                r_total <= sat;
            end
        end
    end

    // input stage
    logic                  r_s0_vld;
    logic [INDEX_BITS-1:0] r_s0_idx;
    tui_pkg::t_status      r_s0_st;
    tui_pkg::t_status      n_s0_st;

    assign o_ready = en && !r_busy;

    always_comb begin
        if (mode_bad) begin
            n_s0_st = tui_pkg::ST_MODE_OVER;
        end else if ({1'b0, i_linear_index} >= r_total) begin
            n_s0_st = tui_pkg::ST_INDEX_OVER;
        end else begin
            n_s0_st = tui_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld <= i_valid && !r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_idx <= i_linear_index;
            r_s0_st  <= n_s0_st;
        end
    end

    // index / stride
    logic                  d1_vld;
    logic [INDEX_BITS-1:0] d1_q;
    logic [W-1:0]          d1_r;
    logic [1:0]            d1_side;

    tui_div_pipe #(.N(INDEX_BITS), .M(W), .PW(2)) u_div_stride (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_s0_vld),
        .i_dividend (r_s0_idx),
        .i_divisor  (r_stride),
        .i_side     (r_s0_st),
        .o_valid    (d1_vld),
        .o_quot     (d1_q),
        .o_rem      (d1_r),
        .o_side     (d1_side)
    );

    // quotient / size along mode k
    logic                         d2_vld;
    logic [INDEX_BITS-1:0]        d2_q;
    logic [DIM_BITS-1:0]          d2_r;
    logic [INDEX_BITS+1:0]        d2_side;

    tui_div_pipe #(.N(INDEX_BITS), .M(DIM_BITS), .PW(INDEX_BITS + 2)) u_div_mode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (d1_vld),
        .i_dividend (d1_q),
        .i_divisor  (r_size_k),
        .i_side     ({d1_r[INDEX_BITS-1:0], d1_side}),
        .o_valid    (d2_vld),
        .o_quot     (d2_q),
        .o_rem      (d2_r),
        .o_side     (d2_side)
    );

    // multiply stage
    logic                    r_m_vld;
    logic [INDEX_BITS-1:0]   r_m_prod;
    logic [INDEX_BITS-1:0]   r_m_low;
    logic [DIM_BITS-1:0]     r_m_row;
    tui_pkg::t_status        r_m_st;
    logic [2*INDEX_BITS-1:0] mprod;

    assign mprod = d2_q * r_stride[INDEX_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (en) begin
            r_m_vld <= d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_prod <= mprod[INDEX_BITS-1:0];
            r_m_low  <= d2_side[INDEX_BITS+1:2];
            r_m_row  <= d2_r;
            r_m_st   <= tui_pkg::t_status'(d2_side[1:0]);
        end
    end

    // output register
    logic                  r_o_vld;
    logic [DIM_BITS-1:0]   r_o_row;
    logic [INDEX_BITS-1:0] r_o_col;
    tui_pkg::t_status      r_o_st;

    assign en = !r_o_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_st <= r_m_st;
            if (r_m_st == tui_pkg::ST_OK) begin
                r_o_row <= r_m_row;
                r_o_col <= r_m_prod + r_m_low;
            end else begin
                r_o_row <= '0;
                r_o_col <= '0;
            end
        end
    end

    assign o_valid         = r_o_vld;
    assign o_unfold_row    = r_o_row;
    assign o_unfold_column = r_o_col;
    assign o_status        = r_o_st;

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != tui_pkg::ST_OK)) |->
        ((o_unfold_row == '0) && (o_unfold_column == '0)))
        else $error("error item carries nonzero coordinates");

    a_busy_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_ready)
        else $error("item taken while strides recompute");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status != 2'd3))
        else $error("undefined status code");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (r_m_vld == $past(r_m_vld)))
        else $error("pipeline moved during stall");

endmodule
